// ===== src/sem_pkg.sv =====
// Shared types, constants and codes for the RGB Sobel edge magnitude block.
package sem_pkg;

  // Default line store depth and image limits
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int HW            = 13;    // row counter and height width

  // Register reset values
  localparam logic [10:0]   RESET_WIDTH  = 11'd640;
  localparam logic [HW-1:0] RESET_HEIGHT = 13'd480;

  // Register indexes on the configuration port
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Datapath widths
  localparam int PIX_W  = 24;   // packed RGB
  localparam int GRAD_W = 11;   // signed gradient, |g| <= 1020
  localparam int SUM_W  = 21;   // gx^2 + gy^2 <= 2080800

  // Magnitude saturation: sums above this round to more than 255
  localparam logic [SUM_W-1:0] MAG_LIMIT = 21'd65280;
  localparam logic [7:0]       MAG_MAX   = 8'd255;

  // Square root iterations, one result bit each
  localparam int SQRT_STEPS = 8;

  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic [8:0][PIX_W-1:0]     win_t;   // 3x3 window, index row*3+col
  typedef logic [2:0][SUM_W-1:0]     sum3_t;  // per channel, red first
  typedef logic [2:0][7:0]           mag3_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX,
    S_DRAIN,
    S_LOAD,
    S_ROOT,
    S_OUT
  } fsm_t;

endpackage

// ===== src/sem_line_mem.sv =====
// Two-row line store: one synchronous memory, older row and newer row per column.
module sem_line_mem import sem_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [2*PIX_W-1:0]   wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [2*PIX_W-1:0]   rd_data
);

  logic [2*PIX_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/sem_grad.sv =====
// Sobel gradients per channel and sum of squares, two register stages.
module sem_grad import sem_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  win_t   win,
  input  logic [8:0] mask,
  output logic   sum_valid,
  output sum3_t  sums
);

  logic signed [GRAD_W-1:0] gx [3];
  logic signed [GRAD_W-1:0] gy [3];
  logic signed [11:0]       gx_c [3];
  logic signed [11:0]       gy_c [3];
  logic signed [11:0]       p [3][9];
  logic signed [21:0]       sq_x [3];
  logic signed [21:0]       sq_y [3];
  logic [21:0]              sum_c [3];
  logic                     g_valid;

  // Masked pixels, zero outside the image
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        p[ch][k] = mask[k] ? $signed({4'b0, win[k][16-8*ch +: 8]}) : 12'sd0;
      end
      gx_c[ch] = (p[ch][2] - p[ch][0]) + (p[ch][5] - p[ch][3])
               + (p[ch][5] - p[ch][3]) + (p[ch][8] - p[ch][6]);
      gy_c[ch] = (p[ch][6] - p[ch][0]) + (p[ch][7] - p[ch][1])
               + (p[ch][7] - p[ch][1]) + (p[ch][8] - p[ch][2]);
    end
  end

  // Squares, then sum
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sq_x[ch]  = gx[ch] * gx[ch];
      sq_y[ch]  = gy[ch] * gy[ch];
      sum_c[ch] = 22'(sq_x[ch]) + 22'(sq_y[ch]);
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      gx[ch]   <= gx_c[ch][GRAD_W-1:0];
      gy[ch]   <= gy_c[ch][GRAD_W-1:0];
      sums[ch] <= sum_c[ch][SUM_W-1:0];
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid   <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      g_valid   <= load;
      sum_valid <= g_valid;
    end
  end

endmodule

// ===== src/sem_sqrt.sv =====
// Iterative rounded integer square root, three channels side by side.
module sem_sqrt import sem_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  sum3_t sums,
  output logic  done,
  output mag3_t mag
);

  localparam int CNTW = $clog2(SQRT_STEPS + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [15:0]     sval  [3];
  logic [10:0]     rem   [3];
  logic [7:0]      acc   [3];
  logic            clamp [3];
  logic [10:0]     rem_sh [3];
  logic [10:0]     trial  [3];
  logic            fit    [3];
  logic [10:0]     rem_it [3];
  logic [7:0]      acc_it [3];
  logic [7:0]      mag_c  [3];

  // One root bit per step; final remainder gives the rounding
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rem_sh[ch] = {rem[ch][8:0], sval[ch][15:14]};
      trial[ch]  = {1'b0, acc[ch], 2'b01};
      fit[ch]    = rem_sh[ch] >= trial[ch];
      rem_it[ch] = fit[ch] ? rem_sh[ch] - trial[ch] : rem_sh[ch];
      acc_it[ch] = {acc[ch][6:0], fit[ch]};
      if (clamp[ch]) begin
        mag_c[ch] = MAG_MAX;
      end else if (rem[ch] > {3'b0, acc[ch]}) begin
        mag_c[ch] = acc[ch] + 8'd1;
      end else begin
        mag_c[ch] = acc[ch];
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNTW'(SQRT_STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CNTW'(1);
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (start) begin
        sval[ch]  <= sums[ch][15:0];
        clamp[ch] <= sums[ch] > MAG_LIMIT;
        rem[ch]   <= '0;
        acc[ch]   <= '0;
      end else if (busy && cnt != CNTW'(SQRT_STEPS)) begin
        sval[ch] <= {sval[ch][13:0], 2'b00};
        rem[ch]  <= rem_it[ch];
        acc[ch]  <= acc_it[ch];
      end else if (busy) begin
        mag[ch] <= mag_c[ch];
      end
    end
  end

endmodule

// ===== src/sobel_edge_magnitude_rgb.sv =====
// Top level: streaming 3x3 Sobel edge magnitude on RGB pixels.
// A result passes through the window register, the two gradient stages, the square root
// and the output register; a drain in the last row first makes three line store reads.
// Items are taken one at a time: in_ready is high only while idle, so the next item waits
// until the last has finished, including the 8-step square root unit for a result.
// Reset: counters return to zero, size registers to 640 x 480; the line store
// keeps its contents and needs no clearing.
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  edge_red,
  output logic [7:0]  edge_green,
  output logic [7:0]  edge_blue,
  output logic        frame_end
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  fsm_t state, state_next;

  logic [10:0]   width_reg, width_reg_next;
  logic [HW-1:0] height_reg, height_reg_next;
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic [CW-1:0]   in_col, in_col_next, out_col, out_col_next;
  logic [HW-1:0]   in_row, in_row_next;
  logic [HW-2:0]   out_row, out_row_next;
  logic [1:0]      dcnt, dcnt_next;
  logic            out_valid_next;

  win_t  win, win_next, twin, twin_next, win_shift, win_zero;
  pix_t  pix_hold, pix_hold_next;
  logic  last_hold, last_hold_next;
  logic  load_out;

  logic               mem_wr_en;
  logic [2*PIX_W-1:0] mem_wr_data;
  logic [AW-1:0]      mem_rd_addr;
  logic [2*PIX_W-1:0] mem_rd_data;

  logic        accept, frame_in_done, drain_like, last_row, last_now;
  logic [HW-1:0] out_row_p1;
  logic [CW-1:0] in_col_p1, out_col_p1;
  logic [2:0]  row_ok, col_ok;
  logic [8:0]  mask;

  logic  grad_load, sum_valid, root_done;
  sum3_t sums;
  mag3_t mag;

  // Effective image size
  always_comb begin
    if (width_reg == '0) begin
      w_eff = CW'(1);
    end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_reg);
    end
    if (height_reg == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = height_reg;
    end
  end

  // Status terms
  assign accept        = in_valid && in_ready;
  assign frame_in_done = in_row >= h_eff;
  assign drain_like    = req_type || frame_in_done;
  assign out_row_p1    = {1'b0, out_row} + HW'(1);
  assign out_col_p1    = out_col + CW'(1);
  assign in_col_p1     = in_col + CW'(1);
  assign last_row      = out_row_p1 >= h_eff;
  assign last_now      = (out_row_p1 == h_eff) && (out_col_p1 == w_eff);
  assign in_ready      = (state == S_IDLE);

  // Window shifted left by a column, zero or the new column entering
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_zero[r*3+0]  = win[r*3+1];
      win_zero[r*3+1]  = win[r*3+2];
      win_zero[r*3+2]  = '0;
      win_shift[r*3+0] = win[r*3+1];
      win_shift[r*3+1] = win[r*3+2];
    end
    win_shift[2] = mem_rd_data[2*PIX_W-1:PIX_W];
    win_shift[5] = mem_rd_data[PIX_W-1:0];
    win_shift[8] = pix_hold;
  end

  // Border mask around the output position
  always_comb begin
    row_ok = {!last_row, 1'b1, out_row != '0};
    col_ok = {out_col_p1 < w_eff, 1'b1, out_col != '0};
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mask[r*3+c] = row_ok[r] && col_ok[c];
      end
    end
  end

  // Sequencer: next state, counters, line store access, size register writes
  always_comb begin
    state_next      = state;
    in_col_next     = in_col;
    in_row_next     = in_row;
    out_col_next    = out_col;
    out_row_next    = out_row;
    dcnt_next       = dcnt;
    win_next        = win;
    twin_next       = twin;
    pix_hold_next   = pix_hold;
    last_hold_next  = last_hold;
    width_reg_next  = width_reg;
    height_reg_next = height_reg;
    out_valid_next  = out_valid && !out_ready;
    load_out        = 1'b0;
    grad_load       = 1'b0;
    mem_wr_en       = 1'b0;
    mem_wr_data     = {mem_rd_data[PIX_W-1:0], pix_hold};
    mem_rd_addr     = in_col[AW-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          pix_hold_next = {red, green, blue};
          if (!drain_like) begin
            state_next = S_PIX;
          end else if (frame_in_done) begin
            if (last_row) begin
              // last row reads the two stored rows around the output column
              mem_rd_addr = out_col[AW-1:0] - AW'(1);
              dcnt_next   = '0;
              state_next  = S_DRAIN;
            end else begin
              twin_next  = win_zero;
              state_next = S_LOAD;
            end
          end
        end
      end
      S_PIX: begin
        win_next  = win_shift;
        mem_wr_en = 1'b1;
        if (in_col_p1 >= w_eff) begin
          in_col_next = '0;
          in_row_next = in_row + HW'(1);
        end else begin
          in_col_next = in_col_p1;
        end
        if (in_col == '0 && in_row >= HW'(2)) begin
          // right edge output of the row before
          twin_next  = win_zero;
          state_next = S_LOAD;
        end else if (in_col != '0 && in_row != '0) begin
          twin_next  = win_shift;
          state_next = S_LOAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DRAIN: begin
        for (int d = 0; d < 3; d++) begin
          if (dcnt == 2'(d)) begin
            twin_next[d]   = mem_rd_data[2*PIX_W-1:PIX_W];
            twin_next[3+d] = mem_rd_data[PIX_W-1:0];
            twin_next[6+d] = '0;
          end
        end
        mem_rd_addr = out_col[AW-1:0] + AW'(dcnt);
        if (dcnt == 2'd2) begin
          state_next = S_LOAD;
        end else begin
          dcnt_next = dcnt + 2'd1;
        end
      end
      S_LOAD: begin
        grad_load      = 1'b1;
        last_hold_next = last_now;
        if (out_col_p1 >= w_eff) begin
          out_col_next = '0;
          out_row_next = out_row + (HW-1)'(1);
        end else begin
          out_col_next = out_col_p1;
        end
        if (last_now) begin
          in_col_next  = '0;
          in_row_next  = '0;
          out_col_next = '0;
          out_row_next = '0;
        end
        state_next = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Register writes restart the frame
    if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_reg_next  = cfg_data[10:0];
        REG_IMAGE_HEIGHT: height_reg_next = cfg_data[HW-1:0];
        default: ;
      endcase
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      dcnt       <= '0;
      out_valid  <= 1'b0;
      width_reg  <= RESET_WIDTH;
      height_reg <= RESET_HEIGHT;
    end else begin
      state      <= state_next;
      in_col     <= in_col_next;
      in_row     <= in_row_next;
      out_col    <= out_col_next;
      out_row    <= out_row_next;
      dcnt       <= dcnt_next;
      out_valid  <= out_valid_next;
      width_reg  <= width_reg_next;
      height_reg <= height_reg_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    win       <= win_next;
    twin      <= twin_next;
    pix_hold  <= pix_hold_next;
    last_hold <= last_hold_next;
    if (load_out) begin
      edge_red   <= mag[0];
      edge_green <= mag[1];
      edge_blue  <= mag[2];
      frame_end  <= last_hold;
    end
  end

  sem_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (in_col[AW-1:0]),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  sem_grad u_grad (
    .clk       (clk),
    .rst       (rst),
    .load      (grad_load),
    .win       (twin),
    .mask      (mask),
    .sum_valid (sum_valid),
    .sums      (sums)
  );

  sem_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sum_valid),
    .sums  (sums),
    .done  (root_done),
    .mag   (mag)
  );

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (rst) in_col < w_eff)
    else $error("input column beyond image width");
  a_row_in_range: assert property (@(posedge clk) disable iff (rst) in_row <= h_eff)
    else $error("input row beyond image height");
  a_sum_in_root: assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> state == S_ROOT)
    else $error("gradient sum outside root wait");
  a_done_in_root: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == S_ROOT)
    else $error("root result outside root wait");
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && last_now) |=>
      (in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0))
    else $error("counters not cleared after last output");
`endif

endmodule

// ===== dv/tb_sobel_edge_magnitude_rgb.sv =====
// Testbench for the RGB Sobel edge magnitude block: directed cases and random framed streams checked by a predictor.
module tb_sobel_edge_magnitude_rgb;
  timeunit 1ns;
  timeprecision 1ps;
  import sem_pkg::*;

  localparam int STALL_LIMIT = 3000;  // cycles with no transfer before giving up
  localparam int SETTLE      = 30;    // cycles after the last result before the sender goes on
  localparam int NUM_ITEMS   = 850;

  typedef struct {
    logic [7:0] r, g, b;
    logic       fe;
  } edge_px_t;

  // Predictor of the edge stream plus the queue of expected pixels
  class edge_scoreboard;
    logic [23:0] row_prev2[DEF_MAX_WIDTH];
    logic [23:0] row_prev1[DEF_MAX_WIDTH];
    logic [23:0] win[9];
    int in_col, in_row, out_col, out_row;
    int width_reg, height_reg;
    edge_px_t expected_px[$];
    int errors;

    function new();
      foreach (row_prev2[i]) begin
        row_prev2[i] = '0;
        row_prev1[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      restart();
      errors = 0;
    endfunction

    function void restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int eff_w();
      return (width_reg < 1) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
    endfunction

    function int eff_h();
      return (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    function void write_reg(logic idx, logic [12:0] val);
      if (idx == REG_IMAGE_WIDTH) width_reg = val[10:0];
      else width_reg = width_reg;
      if (idx == REG_IMAGE_HEIGHT) height_reg = val;
      restart();
    endfunction

    // rounded integer square root, saturated at 255
    function int magnitude(int s);
      int q, t;
      q = 0;
      for (int i = 11; i >= 0; i--) begin
        t = q | (1 << i);
        if (t * t <= s) q = t;
      end
      if (s - q * q > q) q++;
      return (q > 255) ? 255 : q;
    endfunction

    function void shift_in_zero(output logic [23:0] t[9]);
      for (int r = 0; r < 3; r++) begin
        t[r*3]   = win[r*3+1];
        t[r*3+1] = win[r*3+2];
        t[r*3+2] = '0;
      end
    endfunction

    // one output pixel centered at the output counters
    function void produce(input logic [23:0] t[9]);
      int w, h, rr, cc, gx, gy, v, wx, wy;
      int m[3];
      edge_px_t px;
      bit last;
      w = eff_w();
      h = eff_h();
      for (int ch = 0; ch < 3; ch++) begin
        gx = 0;
        gy = 0;
        for (int k = 0; k < 9; k++) begin
          rr = out_row + k / 3 - 1;
          cc = out_col + k % 3 - 1;
          if (rr < 0 || rr >= h || cc < 0 || cc >= w) continue;
          v = (t[k] >> (16 - 8 * ch)) & 8'hFF;
          wx = (k % 3 - 1) * ((k / 3 == 1) ? 2 : 1);
          wy = (k / 3 - 1) * ((k % 3 == 1) ? 2 : 1);
          gx += v * wx;
          gy += v * wy;
        end
        m[ch] = magnitude(gx * gx + gy * gy);
      end
      last = (out_row + 1 == h) && (out_col + 1 == w);
      px.r = 8'(m[0]);
      px.g = 8'(m[1]);
      px.b = 8'(m[2]);
      px.fe = last;
      expected_px.push_back(px);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      if (last) restart();
    endfunction

    function void note_input(logic req, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [23:0] t[9];
      logic [23:0] pix, col_old, col_new;
      int w, h, ic, cc;
      bit ok;
      w = eff_w();
      h = eff_h();
      // drain tick, or a pixel arriving after the frame input is complete
      if (req || in_row >= h) begin
        if (in_row < h) return;
        if (out_row + 1 >= h) begin
          for (int d = 0; d < 3; d++) begin
            cc = out_col + d - 1;
            ok = cc >= 0 && cc < w;
            t[d]   = ok ? row_prev2[cc] : '0;
            t[3+d] = ok ? row_prev1[cc] : '0;
            t[6+d] = '0;
          end
        end else begin
          shift_in_zero(t);
        end
        produce(t);
        return;
      end
      pix = {r, g, b};
      ic = (in_col >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : in_col;
      col_old = row_prev2[ic];
      col_new = row_prev1[ic];
      // right edge of the previous row finishes at the start of a new row
      if (in_col == 0 && in_row >= 2) begin
        shift_in_zero(t);
        produce(t);
      end
      for (int rr = 0; rr < 3; rr++) begin
        win[rr*3]   = win[rr*3+1];
        win[rr*3+1] = win[rr*3+2];
      end
      win[2] = col_old;
      win[5] = col_new;
      win[8] = pix;
      row_prev2[ic] = col_new;
      row_prev1[ic] = pix;
      if (in_col >= 1 && in_row >= 1) produce(win);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
      edge_px_t e;
      if (expected_px.size() == 0) begin
        report($sformatf("unexpected edge pixel %0d/%0d/%0d fe=%0b", r, g, b, fe));
        return;
      end
      e = expected_px.pop_front();
      if (r !== e.r) report($sformatf("edge_red %0d, want %0d", r, e.r));
      if (g !== e.g) report($sformatf("edge_green %0d, want %0d", g, e.g));
      if (b !== e.b) report($sformatf("edge_blue %0d, want %0d", b, e.b));
      if (fe !== e.fe) report($sformatf("frame_end %0b, want %0b", fe, e.fe));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [7:0]  red = '0, green = '0, blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  edge_red, edge_green, edge_blue;
  logic        frame_end;

  edge_scoreboard sb = new();
  bit  steady = 1'b0;  // no random gaps or new output stalls while set
  int  idle_cycles = 0;
  int  ready_hold = 0;
  int  sent = 0;

  sobel_edge_magnitude_rgb i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output side stalls
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 20) ready_hold <= pick_gap();
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(req_type, red, green, blue);
    if (!rst && out_valid && out_ready) sb.check_result(edge_red, edge_green, edge_blue, frame_end);
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task send_item(logic req, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // hold the sender until every expected pixel has come out
  task wait_idle();
    in_valid <= 1'b0;
    // let the monitor note the last transfer first
    @(posedge clk);
    while (sb.expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [12:0] val);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task send_pixel();
    send_item(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  // one frame: pixels with stray drains, then the flush with stray pixels; abandoned frames skip the flush
  task run_frame(int w, int h);
    int npix;
    write_reg(REG_IMAGE_WIDTH, 13'(w));
    write_reg(REG_IMAGE_HEIGHT, 13'(h));
    npix = w * h;
    if ($urandom_range(0, 99) < 8) npix = $urandom_range(0, npix);  // abandoned frame
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 99) < 4) send_item(1'b1, '0, '0, '0);
      send_pixel();
      if ($urandom_range(0, 99) < 2) wait_idle();
    end
    if (npix < w * h) return;
    for (int i = 0; i <= w; i++) begin
      if ($urandom_range(0, 99) < 15) send_pixel();
      else send_item(1'b1, 8'($urandom_range(0, 255)), '0, '0);
    end
    if ($urandom_range(0, 99) < 20) send_item(1'b1, '0, '0, '0);
  endtask

  initial begin
    int w, h, k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 3x3 checkerboard with full-scale values, saturating magnitudes
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    send_item(1'b1, 8'hFF, 8'hFF, 8'hFF);  // drain before frame input is done
    for (int i = 0; i < 9; i++) begin
      if (i % 2 == 0) send_item(1'b0, 8'hFF, 8'h00, 8'hFF);
      else send_item(1'b0, 8'h00, 8'hFF, 8'h00);
    end
    send_item(1'b0, 8'hAA, 8'h55, 8'hAA);  // pixel during flush acts as a drain
    for (int i = 0; i < 3; i++) send_item(1'b1, '0, '0, '0);
    send_item(1'b1, '0, '0, '0);           // drain after frame is complete
    // zero sizes clamp to a single pixel
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_item(1'b1, '0, '0, '0);
    send_item(1'b1, '0, '0, '0);
    // oversize values clamp to the maximum; frame restarted partway
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    repeat (4) send_pixel();
    write_reg(REG_IMAGE_HEIGHT, 13'd4096);
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    repeat (4) send_pixel();

    // random frames, mostly small
    sent = 0;
    k = 0;
    while (sent < NUM_ITEMS) begin
      steady = (k % 7 == 3);
      k++;
      if ($urandom_range(0, 99) < 10) begin
        w = $urandom_range(3, 40);
        h = $urandom_range(1, 4);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 6);
      end
      run_frame(w, h);
    end
    steady = 1'b0;

    wait_idle();
    if (sb.expected_px.size() != 0) sb.report("expected edge pixels left over");
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sem_pkg.sv
src/sem_line_mem.sv
src/sem_grad.sv
src/sem_sqrt.sv
src/sobel_edge_magnitude_rgb.sv
dv/tb_sobel_edge_magnitude_rgb.sv
